// File: rtl/hsp_pkg.sv
`default_nettype none

package hsp_pkg;

    localparam int KEY_COUNT = 9;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [3:0] KEY_LEN_MAX = 4'd15;
    localparam logic [8:0] ALL_KEYS    = 9'h1FF;
    localparam logic [4:0] NO_TARGET   = 5'd31;

    // key indexes
    localparam logic [3:0] KEY_BPMS  = 4'd6;
    localparam logic [3:0] KEY_STOPS = 4'd7;
    localparam logic [3:0] KEY_NOTES = 4'd8;
    localparam logic [3:0] KEY_NONE  = 4'd9;
    localparam logic [3:0] KEY_HDR_END = 4'd6;

    localparam logic [79:0] KEY_TEXT [KEY_COUNT] = '{
        80'("TITLE"), 80'("ARTIST"), 80'("BANNER"), 80'("BACKGROUND"), 80'("MUSIC"),
        80'("OFFSET"), 80'("BPMS"), 80'("STOPS"), 80'("NOTES")
    };
    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
        4'd5, 4'd6, 4'd6, 4'd10, 4'd5, 4'd6, 4'd4, 4'd5, 4'd5
    };

    // chart fields: first chart field tag is CHART_BASE + 1
    localparam logic [4:0] CHART_BASE      = 5'd5;
    localparam logic [2:0] CHART_FIELD_END = 3'd6;

    localparam logic [2:0] KIND_TEXT  = 3'd0;
    localparam logic [2:0] KIND_BPMS  = 3'd1;
    localparam logic [2:0] KIND_STOPS = 3'd2;
    localparam logic [2:0] KIND_CHART = 3'd3;
    localparam logic [2:0] KIND_NOTES = 3'd4;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_KEY   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam logic [1:0] CM_NONE    = 2'd0;
    localparam logic [1:0] CM_SLASH   = 2'd1;
    localparam logic [1:0] CM_COMMENT = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] phase;
        logic [8:0] cand;
        logic [3:0] klen;
        logic [2:0] cfi;
        logic       skip;
        logic [4:0] target;
    } t_parse_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  field;
        logic [7:0]  text_byte;
        logic [31:0] position;
        logic        last;
    } t_result;

    typedef struct packed {
        t_parse_state st;
        logic         emit;
        t_result      res;
    } t_parse_out;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result mk_result(logic [2:0] kind, logic [3:0] fld,
                                          logic [7:0] b, logic [31:0] pos);
        t_result r;
        r.kind      = kind;
        r.field     = fld;
        r.text_byte = b;
        r.position  = pos;
        r.last      = 1'b0;
        return r;
    endfunction

    // One character through the record parser; at most one result.
    function automatic t_parse_out parse_char(t_parse_state s, logic [7:0] c,
                                              logic [31:0] pos);
        t_parse_out o;
        logic [3:0] hit;
        logic [3:0] idx;
        o.st   = s;
        o.emit = 1'b0;
        o.res  = mk_result(KIND_TEXT, 4'd0, 8'd0, 32'd0);
        hit    = KEY_NONE;
        idx    = 4'd0;
        unique case (s.phase)
            PH_KEY: begin
                if (c == CH_COLON) begin
                    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
                        if (s.cand[i] && s.klen == KEY_LEN[i]) begin
                            hit = 4'(i);
                        end
                    end
                    o.st.cand   = ALL_KEYS;
                    o.st.klen   = 4'd0;
                    o.st.phase  = PH_VALUE;
                    o.st.skip   = 1'b1;
                    o.st.target = NO_TARGET;
                    if (hit < KEY_HDR_END) begin
                        o.st.target = {1'b0, hit};
                    end else if (hit == KEY_BPMS) begin
                        o.emit = 1'b1;
                        o.res  = mk_result(KIND_BPMS, 4'd0, 8'd0, pos);
                    end else if (hit == KEY_STOPS) begin
                        o.emit = 1'b1;
                        o.res  = mk_result(KIND_STOPS, 4'd0, 8'd0, pos);
                    end else if (hit == KEY_NOTES) begin
                        o.emit   = 1'b1;
                        o.res    = mk_result(KIND_CHART, 4'd0, 8'd0, pos);
                        o.st.cfi = 3'd1;
                    end
                end else begin
                    for (int i = 0; i < KEY_COUNT; i++) begin
                        if (s.klen >= KEY_LEN[i]) begin
                            o.st.cand[i] = 1'b0;
                        end else begin
                            idx = KEY_LEN[i] - 4'd1 - s.klen;
                            if (KEY_TEXT[i][8*int'(idx) +: 8] != c) begin
                                o.st.cand[i] = 1'b0;
                            end
                        end
                    end
                    if (s.klen < KEY_LEN_MAX) begin
                        o.st.klen = s.klen + 4'd1;
                    end
                end
            end
            PH_VALUE: begin
                if (c == CH_SEMI) begin
                    o.st.phase  = PH_IDLE;
                    o.st.target = NO_TARGET;
                    o.st.cfi    = 3'd0;
                end else begin
                    if (s.cfi != 3'd0) begin
                        if (s.target == NO_TARGET) begin
                            o.st.skip   = 1'b1;
                            o.st.target = CHART_BASE + {2'b0, s.cfi};
                        end
                        if (c == CH_COLON) begin
                            o.st.cfi = s.cfi + 3'd1;
                            if (o.st.cfi >= CHART_FIELD_END) begin
                                o.emit   = 1'b1;
                                o.res    = mk_result(KIND_NOTES, 4'd0, 8'd0, pos);
                                o.st.cfi = 3'd0;
                            end
                            o.st.target = NO_TARGET;
                        end
                    end
                    if (o.st.skip && c != CH_SPACE && c != CH_LF && c != CH_CR) begin
                        o.st.skip = 1'b0;
                    end
                    if (o.st.target != NO_TARGET && !o.st.skip) begin
                        o.emit = 1'b1;
                        o.res  = mk_result(KIND_TEXT, o.st.target[3:0], c, 32'd0);
                    end
                end
            end
            default: begin
                o.st.phase = (c == CH_HASH) ? PH_KEY : PH_IDLE;
            end
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hsp_core.sv
`default_nettype none

module hsp_core #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic [7:0]     i_byte,
    output hsp_pkg::t_push      o_push
);
    import hsp_pkg::*;

    logic [1:0]               r_cm;
    t_parse_state             r_st;
    logic [POSITION_BITS-1:0] r_count;

    logic [1:0]               n_cm;
    t_parse_state             n_st;
    logic [POSITION_BITS-1:0] n_count;
    logic [POSITION_BITS+31:0] count_ext;
    logic [31:0]              pos;
    logic [7:0]               char0;
    logic                     do0;
    logic                     do1;
    t_parse_out               p0;
    t_parse_out               p1;
    t_parse_state             st_mid;
    logic                     e0;
    logic                     e1;

    assign n_count   = r_count + POSITION_BITS'(1);
    assign count_ext = {32'd0, n_count};
    assign pos       = count_ext[31:0];

    // a held slash is released ahead of the byte that follows it
    always_comb begin
        char0 = (r_cm == CM_SLASH) ? CH_SLASH : i_byte;
        do0   = 1'b0;
        do1   = 1'b0;
        n_cm  = r_cm;
        unique case (r_cm)
            CM_COMMENT: begin
                if (i_byte == CH_LF) begin
                    n_cm = CM_NONE;
                    do0  = 1'b1;
                end
            end
            CM_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    n_cm = CM_COMMENT;
                end else begin
                    n_cm = CM_NONE;
                    do0  = 1'b1;
                    do1  = 1'b1;
                end
            end
            default: begin
                if (i_byte == CH_SLASH) begin
                    n_cm = CM_SLASH;
                end else begin
                    do0 = 1'b1;
                end
            end
        endcase
    end

    assign p0     = parse_char(r_st, char0, pos);
    assign st_mid = do0 ? p0.st : r_st;
    assign p1     = parse_char(st_mid, i_byte, pos);
    assign n_st   = do1 ? p1.st : st_mid;
    assign e0     = do0 && p0.emit;
    assign e1     = do1 && p1.emit;

    always_comb begin
        o_push.n  = 2'd0;
        o_push.r0 = p0.res;
        o_push.r1 = p1.res;
        if (i_take) begin
            if (e0 && e1) begin
                o_push.n       = 2'd2;
                o_push.r1.last = 1'b1;
            end else if (e0) begin
                o_push.n       = 2'd1;
                o_push.r0.last = 1'b1;
            end else if (e1) begin
                o_push.n       = 2'd1;
                o_push.r0      = p1.res;
                o_push.r0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm      <= CM_NONE;
            r_st.phase <= PH_IDLE;
            r_st.cand <= ALL_KEYS;
            r_st.klen <= 4'd0;
            r_st.cfi  <= 3'd0;
            r_st.skip <= 1'b1;
            r_st.target <= NO_TARGET;
            r_count   <= '0;
        end else if (i_take) begin
            r_cm    <= n_cm;
            r_st    <= n_st;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hsp_queue.sv
`default_nettype none

module hsp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hsp_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_room2,
    output logic                o_nonempty,
    output hsp_pkg::t_result    o_head
);
    import hsp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_result       r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_count;

    logic [PW:0]   free_after_pop;

    assign o_nonempty     = (r_count != '0);
    assign o_head         = r_mem[r_rp];
    assign free_after_pop = (PW+1)'(QUEUE_DEPTH) - r_count + {{PW{1'b0}}, i_pop};
    assign o_room2        = (free_after_pop >= (PW+1)'(2));

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wp + PW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PW'(i_push.n);
            r_rp    <= r_rp + {{(PW-1){1'b0}}, i_pop};
            r_count <= r_count + (PW+1)'(i_push.n) - {{PW{1'b0}}, i_pop};
        end
    end

endmodule

`default_nettype wire

// File: rtl/tagged_header_stream_parser.sv
`default_nettype none

// Tagged header stream parser: takes one raw file byte per transfer, strips
// line comments, picks apart #KEY:VALUE; records and issues result transfers
// that are either tagged value bytes (kind 0) or markers carrying the byte
// position just after the colon (BPMS, STOPS, new chart, note data start).
// Each input byte gives zero, one or two results; o_last marks the final
// result of a byte. Rate: one byte per clock cycle while the output side
// keeps up. A byte that releases a held slash can give two results; the
// four-entry result queue absorbs short bursts, and input stalls only when
// it cannot take two more results. A byte goes into the input register and
// its results then into the result queue, from which they are offered; the
// byte waits in the input register while the queue lacks room.
// Positions count raw bytes modulo 2^POSITION_BITS and are presented as the
// low 32 bits.

module tagged_header_stream_parser #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [3:0]       o_field,
    output logic [7:0]       o_text_byte,
    output logic [31:0]      o_position,
    output logic             o_last
);
    import hsp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       take;
    logic       accept;
    logic       pop;
    logic       room2;
    t_push      push;
    t_result    head;

    // advance the held byte only when the queue can absorb its worst case
    assign take    = r_in_valid && room2;
    assign o_stall = r_in_valid && !room2;
    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    // hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte_in;
        end
    end

    hsp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    hsp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_room2    (room2),
        .o_nonempty (o_valid),
        .o_head     (head)
    );

    assign o_kind      = head.kind;
    assign o_field     = head.field;
    assign o_text_byte = head.text_byte;
    assign o_position  = head.position;
    assign o_last      = head.last;

endmodule

`default_nettype wire

// File: bench/tb_tagged_header_stream_parser.sv
`timescale 1ns / 100ps

module tb_tagged_header_stream_parser;

    import hsp_pkg::*;

    // Generous ceiling: about 560 bytes, up to two results each, with a quarter
    // of the cycles lost on either side plus one long output hold.
    localparam int CYCLE_LIMIT = 200000;

    // Flat window, counted in accepted bytes, in which neither side idles.
    localparam int FLAT_FROM  = 150;
    localparam int FLAT_TO    = 270;
    // Long output hold: starts once this many bytes are in, lasts this long.
    localparam int HOLD_AT    = 350;
    localparam int HOLD_LEN   = 80;
    localparam int BYTE_GOAL  = 560;
    localparam int SETTLE     = 10;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_byte_in = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [3:0]  o_field;
    logic [7:0]  o_text_byte;
    logic [31:0] o_position;
    logic        o_last;

    tagged_header_stream_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_byte_in   (i_byte_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_field     (o_field),
        .o_text_byte (o_text_byte),
        .o_position  (o_position),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Key names in match priority order; the index is the key code.
    string key_words [KEY_COUNT] = '{
        "TITLE", "ARTIST", "BANNER", "BACKGROUND", "MUSIC",
        "OFFSET", "BPMS", "STOPS", "NOTES"
    };

    // Raw file bytes still to be offered, and results the parser owes us.
    logic [7:0] byte_backlog [$];
    t_result    results_due [$];
    t_result    head_due;

    int  cycle_count = 0;
    int  bytes_taken = 0;
    int  mismatches  = 0;
    int  hold_left   = 0;
    bit  hold_fired  = 1'b0;
    wire no_gaps     = (bytes_taken >= FLAT_FROM) && (bytes_taken < FLAT_TO);

    // Shadow of the parser state.
    logic [1:0]  cmt_state   = CM_NONE;
    logic [1:0]  rec_phase   = PH_IDLE;
    logic [8:0]  key_live    = ALL_KEYS;
    logic [3:0]  key_seen    = 4'd0;
    logic [2:0]  chart_slot  = 3'd0;
    logic        trim_lead   = 1'b1;
    logic [4:0]  tag_sel     = NO_TARGET;
    logic [31:0] raw_pos     = 32'd0;

    task automatic owe_result(input logic [2:0] kind, input logic [3:0] fld,
                              input logic [7:0] b, input logic [31:0] pos);
        t_result r;
        r.kind      = kind;
        r.field     = fld;
        r.text_byte = b;
        r.position  = pos;
        r.last      = 1'b0;
        results_due = {results_due, r};
    endtask

    // Advance the record parser by one character left after comment removal.
    task automatic track_char(input logic [7:0] c);
        int hit;
        hit = KEY_NONE;
        case (rec_phase)
            PH_KEY: begin
                if (c == CH_COLON) begin
                    // first surviving key of the right length wins
                    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
                        if (key_live[i] && key_seen == key_words[i].len()) begin
                            hit = i;
                        end
                    end
                    key_live  = ALL_KEYS;
                    key_seen  = 4'd0;
                    rec_phase = PH_VALUE;
                    trim_lead = 1'b1;
                    tag_sel   = NO_TARGET;
                    if (hit < KEY_BPMS) begin
                        tag_sel = 5'(hit);
                    end else if (hit == KEY_BPMS) begin
                        owe_result(KIND_BPMS, 4'd0, 8'd0, raw_pos);
                    end else if (hit == KEY_STOPS) begin
                        owe_result(KIND_STOPS, 4'd0, 8'd0, raw_pos);
                    end else if (hit == KEY_NOTES) begin
                        owe_result(KIND_CHART, 4'd0, 8'd0, raw_pos);
                        chart_slot = 3'd1;
                    end
                end else begin
                    // drop every key that no longer matches at this offset
                    for (int i = 0; i < KEY_COUNT; i++) begin
                        if (key_seen >= key_words[i].len() ||
                            key_words[i][key_seen] != c) begin
                            key_live[i] = 1'b0;
                        end
                    end
                    if (key_seen < KEY_LEN_MAX) begin
                        key_seen = key_seen + 4'd1;
                    end
                end
            end
            PH_VALUE: begin
                if (c == CH_SEMI) begin
                    rec_phase  = PH_IDLE;
                    tag_sel    = NO_TARGET;
                    chart_slot = 3'd0;
                end else begin
                    if (chart_slot != 3'd0) begin
                        if (tag_sel == NO_TARGET) begin
                            trim_lead = 1'b1;
                            tag_sel   = CHART_BASE + 5'(chart_slot);
                        end
                        // a colon closes the chart field; the fifth starts note data
                        if (c == CH_COLON) begin
                            chart_slot = chart_slot + 3'd1;
                            if (chart_slot >= CHART_FIELD_END) begin
                                owe_result(KIND_NOTES, 4'd0, 8'd0, raw_pos);
                                chart_slot = 3'd0;
                            end
                            tag_sel = NO_TARGET;
                        end
                    end
                    if (trim_lead && c != CH_SPACE && c != CH_LF && c != CH_CR) begin
                        trim_lead = 1'b0;
                    end
                    if (tag_sel != NO_TARGET && !trim_lead) begin
                        owe_result(KIND_TEXT, tag_sel[3:0], c, 32'd0);
                    end
                end
            end
            default: begin
                rec_phase = (c == CH_HASH) ? PH_KEY : PH_IDLE;
            end
        endcase
    endtask

    // One accepted raw byte: strip comments, parse, flag the final result.
    task automatic track_byte(input logic [7:0] b);
        int      owed_before;
        t_result tail;
        owed_before = results_due.size();
        raw_pos     = raw_pos + 32'd1;
        case (cmt_state)
            CM_COMMENT: begin
                if (b == CH_LF) begin
                    cmt_state = CM_NONE;
                    track_char(b);
                end
            end
            CM_SLASH: begin
                if (b == CH_SLASH) begin
                    cmt_state = CM_COMMENT;
                end else begin
                    // release the held slash, then handle this byte too
                    cmt_state = CM_NONE;
                    track_char(CH_SLASH);
                    track_char(b);
                end
            end
            default: begin
                if (b == CH_SLASH) begin
                    cmt_state = CM_SLASH;
                end else begin
                    track_char(b);
                end
            end
        endcase
        if (results_due.size() > owed_before) begin
            tail        = results_due.pop_back();
            tail.last   = 1'b1;
            results_due = {results_due, tail};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("mismatch at cycle %0d: %s got %0h want %0h",
                     cycle_count, what, got, want);
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b);
        byte_backlog = {byte_backlog, b};
    endtask

    task automatic add_text(input string s);
        for (int j = 0; j < s.len(); j++) begin
            add_byte(s[j]);
        end
    endtask

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Value content: mostly printable, with whitespace, colons, slashes and
    // arbitrary bytes mixed in; never a semicolon, so records end where we say.
    function automatic logic [7:0] value_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            c = 8'($urandom_range(8'h30, 8'h7A));
        end else if (r < 65) begin
            c = ws_char();
        end else if (r < 72) begin
            c = CH_COLON;
        end else if (r < 78) begin
            c = CH_SLASH;
        end else if (r < 80) begin
            c = CH_HASH;
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        if (c == CH_SEMI) begin
            c = CH_COLON;
        end
        return c;
    endfunction

    task automatic add_values(input int n);
        repeat (n) add_byte(value_char());
    endtask

    // One record, mostly well formed with random content; otherwise a comment
    // line, a missing hash or semicolon, a doubled hash, a truncated or junk key.
    task automatic add_random_record();
        int pick;
        int kid;
        bit chart;
        chart = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            add_text("//");
            add_values($urandom_range(0, 8));
            add_byte(CH_LF);
        end else begin
            if (pick >= 8) begin
                add_byte(CH_HASH);
            end
            kid = $urandom_range(0, KEY_COUNT - 1);
            if (pick < 80) begin
                chart = (kid == KEY_NOTES);
                add_text(key_words[kid]);
            end else if (pick < 86) begin
                add_text(key_words[kid].substr(0, key_words[kid].len() - 2));
            end else if (pick < 90) begin
                add_byte(CH_HASH);
                add_text(key_words[kid]);
            end else begin
                // junk key, sometimes past the length the matcher counts to
                repeat ($urandom_range(1, 18)) add_byte(8'($urandom_range(8'h41, 8'h5A)));
            end
            add_byte(CH_COLON);
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) add_byte(ws_char());
            end
            if (chart) begin
                for (int f = 0; f < 5 && $urandom_range(0, 19) != 0; f++) begin
                    add_values($urandom_range(0, 4));
                    add_byte(CH_COLON);
                end
            end
            add_values($urandom_range(0, 10));
            if ($urandom_range(0, 19) != 0) begin
                add_byte(CH_SEMI);
            end
            if ($urandom_range(0, 1) == 0) begin
                add_byte(CH_LF);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: offer bytes from the backlog, hold while stalled, predict on
    // every transfer.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_byte_in <= 8'h00;
        end else begin
            if (i_valid && !o_stall) begin
                track_byte(i_byte_in);
                bytes_taken <= bytes_taken + 1;
            end
            // only move on once the current byte has gone (or none was offered)
            if (!i_valid || !o_stall) begin
                if (byte_backlog.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 25)) begin
                    i_valid   <= 1'b1;
                    i_byte_in <= byte_backlog.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver stall: random back-pressure, plus one long hold part-way
    // through so that the result queue fills and the input stalls.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && bytes_taken >= HOLD_AT) begin
            hold_fired <= 1'b1;
            hold_left  <= HOLD_LEN;
            i_stall    <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !no_gaps && ($urandom_range(0, 99) < 25);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest one owed.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing owed, kind", 32'(o_kind), 32'd0);
            end else begin
                head_due = results_due.pop_front();
                if (o_kind != head_due.kind) begin
                    report_mismatch("kind", 32'(o_kind), 32'(head_due.kind));
                end
                if (o_field != head_due.field) begin
                    report_mismatch("field", 32'(o_field), 32'(head_due.field));
                end
                if (o_text_byte != head_due.text_byte) begin
                    report_mismatch("text_byte", 32'(o_text_byte), 32'(head_due.text_byte));
                end
                if (o_position != head_due.position) begin
                    report_mismatch("position", o_position, head_due.position);
                end
                if (o_last != head_due.last) begin
                    report_mismatch("last", 32'(o_last), 32'(head_due.last));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_tagged_header_stream_parser: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence: build the byte stream, release reset, drain, judge.
    // ---------------------------------------------------------------------
    initial begin
        // Directed opening: extreme byte values, a held slash released into a
        // chart field (two results from one byte), all five chart colons with
        // note data dropped after the last, and a comment hiding a semicolon.
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("#NOTES: /a:b:c:d::x;");
        add_text("//q;\n");

        while (byte_backlog.size() < BYTE_GOAL) begin
            add_random_record();
        end
        // stream ends on a lone slash, which must never come out
        add_byte(CH_SLASH);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the last byte to be taken, then for the last result
        while (byte_backlog.size() != 0 || i_valid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_tagged_header_stream_parser: done, clean");
        end else begin
            $display("tb_tagged_header_stream_parser: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/hsp_pkg.sv
rtl/hsp_core.sv
rtl/hsp_queue.sv
rtl/tagged_header_stream_parser.sv
bench/tb_tagged_header_stream_parser.sv
